// ===== hdl/sfmr_pkg.sv =====
// Package: shared types, constants and the float compare for the strided min reduction.
package sfmr_pkg;

   localparam int unsigned DefMaxColumns = 256;
   localparam int unsigned SampleWidth   = 32;
   localparam int unsigned ColumnWidth   = 8;
   localparam int unsigned LenWidth      = 9;
   localparam int unsigned PassWidth     = 17;
   localparam int unsigned CsrIdxWidth   = 1;
   localparam int unsigned CsrDataWidth  = 17;
   localparam logic [CsrIdxWidth-1:0] CsrOutLength = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CsrPassCount = 1'd1;
   localparam logic [PassWidth-1:0]   MaxPasses    = 17'd65536;

   typedef struct packed {
      logic [SampleWidth-1:0] sample;
      logic                   first_pass;
      logic                   emit;
      logic                   group_end;
      logic [11:0]            col;
   } job_type;

   function automatic logic is_nan(input logic [31:0] v);
      return v[30:0] > 31'h7F800000;
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] v);
      return v[31] ? ~v : (v | 32'h80000000);
   endfunction

   function automatic logic ordered_less(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
      return order_key(a) < order_key(b);
   endfunction

endpackage

// ===== hdl/sfmr_front.sv =====
// Front end: configuration, column and pass counting, job queue.
module sfmr_front #(
   parameter int unsigned MAX_COLUMNS = sfmr_pkg::DefMaxColumns,
   localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sfmr_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [sfmr_pkg::CsrDataWidth-1:0]   csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,
   output logic                                job_valid,
   input  logic                                job_ready,
   output sfmr_pkg::job_type                   job
);
   localparam logic [sfmr_pkg::LenWidth-1:0] MaxLen =
      (MAX_COLUMNS > 511) ? {sfmr_pkg::LenWidth{1'b1}} : sfmr_pkg::LenWidth'(MAX_COLUMNS);

   logic [sfmr_pkg::LenWidth-1:0]  len_ff, len_in;
   logic [sfmr_pkg::PassWidth-1:0] pc_ff, pc_in;
   logic [CW-1:0]                  col_ff, col_in;
   logic [15:0]                    pass_ff, pass_in;
   sfmr_pkg::job_type              q_ff [2];
   logic [1:0]                     cnt_ff, cnt_in;
   logic                           rd_ff, rd_in, wr_ff, wr_in;
   logic [sfmr_pkg::LenWidth-1:0]  cols;
   logic [sfmr_pkg::PassWidth-1:0] passes;
   logic                           acc, pop, last_col, last_pass;
   sfmr_pkg::job_type              nj;

   always_comb begin
      cols   = (len_ff == '0) ? sfmr_pkg::LenWidth'(1) : (len_ff > MaxLen ? MaxLen : len_ff);
      passes = (pc_ff == '0) ? sfmr_pkg::PassWidth'(1) : pc_ff;
      if (passes > sfmr_pkg::MaxPasses) passes = sfmr_pkg::MaxPasses;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign acc        = req_tvalid && req_tready;
   assign pop        = job_valid && job_ready;
   assign job_valid  = (cnt_ff != 2'd0);
   assign job        = q_ff[rd_ff];
   assign last_col   = (sfmr_pkg::LenWidth'(col_ff) + 1'b1 >= cols);
   assign last_pass  = (sfmr_pkg::PassWidth'(pass_ff) + 1'b1 >= passes);

   always_comb begin
      nj.sample     = req_tdata;
      nj.first_pass = (pass_ff == '0);
      nj.emit       = last_pass;
      nj.group_end  = last_col;
      nj.col        = 12'(col_ff);
      len_in  = len_ff;
      pc_in   = pc_ff;
      col_in  = col_ff;
      pass_in = pass_ff;
      if (acc) begin
         if (last_col) begin
            col_in  = '0;
            pass_in = last_pass ? 16'd0 : pass_ff + 16'd1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            sfmr_pkg::CsrOutLength: len_in = csr_wdata[sfmr_pkg::LenWidth-1:0];
            sfmr_pkg::CsrPassCount: pc_in  = csr_wdata;
            default: ;
         endcase
         col_in  = '0;
         pass_in = '0;
      end
      wr_in  = acc ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, acc} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= sfmr_pkg::LenWidth'(1);
         pc_ff   <= sfmr_pkg::PassWidth'(1);
         col_ff  <= '0;
         pass_ff <= '0;
         cnt_ff  <= '0;
         rd_ff   <= 1'b0;
         wr_ff   <= 1'b0;
      end else begin
         len_ff  <= len_in;
         pc_ff   <= pc_in;
         col_ff  <= col_in;
         pass_ff <= pass_in;
         cnt_ff  <= cnt_in;
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
      end
      if (acc) q_ff[wr_ff] <= nj;
   end
endmodule

// ===== hdl/sfmr_back.sv =====
// Back end: minima memory read-modify-write and result register.
module sfmr_back #(
   parameter int unsigned MAX_COLUMNS = sfmr_pkg::DefMaxColumns,
   localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  sfmr_pkg::job_type job,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tlast
);
   logic [31:0]       mem [MAX_COLUMNS];
   logic [31:0]       rdata_ff;
   logic              s1_ff, s1_in;
   sfmr_pkg::job_type j1_ff;
   logic              ov_ff, ov_in;
   logic [31:0]       om_ff;
   logic [7:0]        oc_ff;
   logic              ol_ff;
   logic [31:0]       val;
   logic [31:0]       acc_v;
   logic              adv;

   // stage 1 holds the read; advance unless an emit is blocked
   assign adv       = !s1_ff || !j1_ff.emit || !ov_ff || rsp_tready;
   assign job_ready = adv;
   assign acc_v     = rdata_ff;
   assign val       = j1_ff.first_pass ? j1_ff.sample :
                      (sfmr_pkg::ordered_less(acc_v, j1_ff.sample) ? acc_v : j1_ff.sample);
   assign s1_in     = adv ? job_valid : s1_ff;
   assign ov_in     = (ov_ff && !rsp_tready) || (adv && s1_ff && j1_ff.emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         ov_ff <= ov_in;
      end
      if (adv) begin
         j1_ff <= job;
         rdata_ff <= (s1_ff && j1_ff.col[CW-1:0] == job.col[CW-1:0]) ? val
                     : mem[job.col[CW-1:0]];
      end
      if (adv && s1_ff) begin
         mem[j1_ff.col[CW-1:0]] <= val;
         if (j1_ff.emit) begin
            om_ff <= val;
            oc_ff <= j1_ff.col[7:0];
            ol_ff <= j1_ff.group_end;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {oc_ff, om_ff};
   assign rsp_tlast  = ol_ff;
endmodule

// ===== hdl/strided_float_min_reduction_unit.sv =====
// Top level of the strided single-precision minimum reduction unit.
//  channel | dir | payload
//  req     | in  | tdata[31:0] sample
//  rsp     | out | tdata[31:0] minimum, [39:32] column; tlast group_end
//  csr     | in  | index 0 out_length, 1 pass_count
// One sample per cycle sustained while rsp is not stalled; a request passes the queue, stage 1 and the result register.
// The minima memory is read as a job enters stage 1 and written back as it leaves stage 1.
// Reset is synchronous; the minima memory needs no clearing.
// A stalled rsp holds the back end once an emitting job is in stage 1; a two-entry queue decouples req.
module strided_float_min_reduction_unit #(
   parameter int unsigned MAX_COLUMNS = sfmr_pkg::DefMaxColumns
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sfmr_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [sfmr_pkg::CsrDataWidth-1:0] csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // minimum, column
   output logic                              rsp_tlast
);
   logic              job_valid, job_ready;
   sfmr_pkg::job_type job;

   sfmr_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .job_valid, .job_ready, .job);

   sfmr_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_q: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> job_valid)
      else $error("queue full but empty");
endmodule
